>>> rtl/core/klc_pkg.sv
// klc_pkg: shared constants, phase encodings and inter-module structs
// for the keypad code lock controller. No dependencies.
package klc_pkg;

	// received characters with a meaning
	localparam logic [7:0] KEY_CONFIRM = 8'h3D; // '='
	localparam logic [7:0] KEY_OPEN    = 8'h2B; // '+'
	localparam logic [7:0] KEY_CHANGE  = 8'h2D; // '-'
	localparam logic [7:0] KEY_RESTART = 8'h0D;

	// bytes sent back to the partner
	localparam logic [7:0] SEND_TAKEN  = 8'd0;
	localparam logic [7:0] SEND_ACK    = 8'd1;
	localparam logic [7:0] SEND_DENIED = 8'd6;

	// motor drive levels
	localparam logic [1:0] DRIVE_STOP = 2'd0;
	localparam logic [1:0] DRIVE_CW   = 2'd1;
	localparam logic [1:0] DRIVE_ACW  = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_NEW_CODE = 3'd1,
		PH_REPEAT   = 3'd2,
		PH_MENU     = 3'd3,
		PH_OPEN     = 3'd4,
		PH_CHANGE   = 3'd5
	} lock_phase_t;

	typedef enum logic [1:0] {
		MP_IDLE  = 2'd0,
		MP_OPEN  = 2'd1,
		MP_PAUSE = 2'd2,
		MP_CLOSE = 2'd3
	} motor_phase_t;

	typedef struct packed {
		logic       send0;
		logic [7:0] first_byte;
		logic       send1;
		logic [7:0] second_byte;
		logic       alarm;
		logic       motor_start;
	} lock_res_t;

	typedef struct packed {
		logic       send;
		logic [1:0] drive;
	} motor_res_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic [1:0] motor_drive;
		logic       alarm;
		logic       last;
	} result_t;

endpackage

>>> rtl/core/klc_if.sv
// klc_if: valid/ready channels of the keypad code lock controller.
// Standalone, no package dependency.
interface klc_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface

interface klc_result_if;
	logic       valid;
	logic       ready;
	logic       send_valid;
	logic [7:0] send_byte;
	logic [1:0] motor_drive;
	logic       alarm;
	logic       last;

	modport source (output valid, output send_valid, output send_byte,
		output motor_drive, output alarm, output last, input ready);
	modport sink (input valid, input send_valid, input send_byte,
		input motor_drive, input alarm, input last, output ready);
endinterface

>>> rtl/core/klc_lock_core.sv
// klc_lock_core: lock phase FSM, code store and entry buffer.
// Depends on klc_pkg.
module klc_lock_core import klc_pkg::*; #(
	parameter int CODE_LENGTH = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_en,
	input  logic [7:0]  key,
	output lock_phase_t phase,
	output lock_res_t   res
);

	localparam int DEPTH = 2 * CODE_LENGTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(CODE_LENGTH + 1);

	lock_phase_t   phase_q, phase_d, eff_phase;
	logic [7:0]    code_q  [DEPTH];
	logic [7:0]    entry_q [CODE_LENGTH];
	logic [PW-1:0] ptr_q, ptr_inc;
	logic [CW-1:0] cnt_q;
	logic          store_we, clr_ptr, entry_we, clr_cnt, start;
	logic          repeat_ok, entry_ok;

	assign eff_phase = (key == KEY_RESTART) ? PH_NEW_CODE : phase_q;
	assign ptr_inc   = (ptr_q == PW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign phase     = phase_q;

	always_comb begin
		repeat_ok = 1'b1;
		entry_ok  = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (code_q[i] != code_q[i + CODE_LENGTH]) repeat_ok = 1'b0;
			if (entry_q[i] != code_q[i]) entry_ok = 1'b0;
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		store_we = 1'b0;
		clr_ptr  = 1'b0;
		entry_we = 1'b0;
		clr_cnt  = 1'b0;
		start    = 1'b0;
		if (key_en) begin
			phase_d = eff_phase;
			case (eff_phase)
				PH_NEW_CODE: begin
					if (key == KEY_CONFIRM) begin
						clr_cnt = 1'b1;
						phase_d = PH_REPEAT;
					end else begin
						store_we = 1'b1;
					end
				end
				PH_REPEAT: begin
					if (key == KEY_CONFIRM) begin
						if (repeat_ok) begin
							phase_d = PH_MENU;
						end else begin
							phase_d = PH_NEW_CODE;
							clr_ptr = 1'b1;
						end
					end else begin
						store_we = 1'b1;
					end
				end
				PH_MENU: begin
					if (key == KEY_CHANGE) phase_d = PH_CHANGE;
					else if (key == KEY_OPEN) phase_d = PH_OPEN;
				end
				PH_OPEN, PH_CHANGE: begin
					if (key == KEY_CONFIRM) begin
						clr_cnt = 1'b1;
						if (!entry_ok) begin
							phase_d = PH_MENU;
						end else if (eff_phase == PH_OPEN) begin
							phase_d = PH_MENU;
							start   = 1'b1;
						end else begin
							phase_d = PH_NEW_CODE;
						end
					end else begin
						entry_we = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		res             = '0;
		res.motor_start = start;
		if (key_en) begin
			case (eff_phase)
				PH_NEW_CODE, PH_REPEAT: begin
					res.send0 = 1'b1;
					if (key == KEY_CONFIRM) begin
						res.first_byte  = SEND_ACK;
						res.send1       = 1'b1;
						res.second_byte = {5'd0, phase_d};
						res.alarm       = (eff_phase == PH_REPEAT) && !repeat_ok;
					end else begin
						res.first_byte = SEND_TAKEN;
					end
				end
				PH_MENU: begin
					if (key == KEY_CHANGE || key == KEY_OPEN) begin
						res.send0       = 1'b1;
						res.first_byte  = SEND_ACK;
						res.send1       = 1'b1;
						res.second_byte = {5'd0, phase_d};
					end
				end
				PH_OPEN, PH_CHANGE: begin
					res.send0 = 1'b1;
					if (key == KEY_CONFIRM) begin
						res.first_byte  = SEND_ACK;
						res.send1       = 1'b1;
						res.alarm       = !entry_ok;
						res.second_byte = (!entry_ok && eff_phase == PH_OPEN) ?
							SEND_DENIED : {5'd0, phase_d};
					end else begin
						res.first_byte = SEND_TAKEN;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NEW_CODE;
			ptr_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < DEPTH; i++) code_q[i] <= '0;
			for (int i = 0; i < CODE_LENGTH; i++) entry_q[i] <= '0;
		end else begin
			phase_q <= phase_d;
			if (clr_ptr) ptr_q <= '0;
			else if (store_we) ptr_q <= ptr_inc;
			for (int i = 0; i < DEPTH; i++) begin
				if (store_we && ptr_q == PW'(i)) code_q[i] <= key;
			end
			if (clr_cnt) begin
				cnt_q <= '0;
			end else if (entry_we && cnt_q < CW'(CODE_LENGTH)) begin
				cnt_q <= cnt_q + 1'b1;
				for (int i = 0; i < CODE_LENGTH; i++) begin
					if (cnt_q == CW'(i)) entry_q[i] <= key;
				end
			end
		end
	end

endmodule

>>> rtl/core/klc_motor_seq.sv
// klc_motor_seq: open / pause / close motor sequencer driven by ticks.
// Depends on klc_pkg.
module klc_motor_seq import klc_pkg::*; #(
	parameter int MOVE_TICKS  = 450,
	parameter int PAUSE_TICKS = 90
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick,
	input  logic       start,
	output motor_res_t res
);

	localparam int TW = $clog2(MOVE_TICKS + 1);
	localparam int PW = (PAUSE_TICKS > 0) ? $clog2(PAUSE_TICKS + 1) : 1;
	localparam logic NO_PAUSE = (PAUSE_TICKS == 0);

	motor_phase_t  mp_q, mp_d;
	logic [TW-1:0] tick_q, tick_d, tick_inc;
	logic [PW-1:0] pause_q, pause_d, pause_inc;
	logic          move_done, pause_done;

	assign tick_inc   = tick_q + 1'b1;
	assign pause_inc  = pause_q + 1'b1;
	assign move_done  = tick_inc >= TW'(MOVE_TICKS);
	assign pause_done = pause_inc >= PW'(PAUSE_TICKS);

	// next state
	always_comb begin
		mp_d    = mp_q;
		tick_d  = tick_q;
		pause_d = pause_q;
		if (start) begin
			mp_d    = MP_OPEN;
			tick_d  = '0;
			pause_d = '0;
		end else if (tick) begin
			case (mp_q)
				MP_OPEN, MP_CLOSE: begin
					tick_d = move_done ? '0 : tick_inc;
					if (move_done) begin
						if (mp_q == MP_OPEN) begin
							pause_d = '0;
							mp_d    = NO_PAUSE ? MP_CLOSE : MP_PAUSE;
						end else begin
							mp_d = MP_IDLE;
						end
					end
				end
				MP_PAUSE: begin
					pause_d = pause_done ? '0 : pause_inc;
					if (pause_done) begin
						tick_d = '0;
						mp_d   = MP_CLOSE;
					end
				end
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		res.send = tick && !start &&
			(((mp_q == MP_CLOSE || (mp_q == MP_OPEN && NO_PAUSE)) && move_done) ||
			 (mp_q == MP_PAUSE && pause_done));
		case (mp_d)
			MP_OPEN:  res.drive = DRIVE_ACW;
			MP_CLOSE: res.drive = DRIVE_CW;
			default:  res.drive = DRIVE_STOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_q    <= MP_IDLE;
			tick_q  <= '0;
			pause_q <= '0;
		end else begin
			mp_q    <= mp_d;
			tick_q  <= tick_d;
			pause_q <= pause_d;
		end
	end

endmodule

>>> rtl/core/klc_result_queue.sv
// klc_result_queue: four-entry result queue, two writes and one read a cycle.
// Depends on klc_pkg and klc_if.
module klc_result_queue import klc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push0,
	input  logic            push1,
	input  result_t         d0,
	input  result_t         d1,
	output logic            room,
	klc_result_if.source    result
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	result_t       mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [NW-1:0] count_q;
	logic          pop;
	result_t       head;

	assign room   = count_q <= NW'(QUEUE_DEPTH - 2);
	assign pop    = result.valid && result.ready;
	assign head   = mem_q[rp_q];

	assign result.valid       = count_q != '0;
	assign result.send_valid  = head.send_valid;
	assign result.send_byte   = head.send_byte;
	assign result.motor_drive = head.motor_drive;
	assign result.alarm       = head.alarm;
	assign result.last        = head.last;

	always_ff @(posedge clk) begin
		if (push0) mem_q[wp_q] <= d0;
		if (push1) mem_q[wp_q + 1'b1] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + AW'(push0) + AW'(push1);
			if (pop) rp_q <= rp_q + 1'b1;
			count_q <= count_q + NW'(push0) + NW'(push1) - NW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(QUEUE_DEPTH))
		else $error("result queue count past depth");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second result pushed without first");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> room)
		else $error("result pushed with no room for two");

endmodule

>>> rtl/core/keypad_code_lock_controller_core.sv
// keypad_code_lock_controller_core: top level of the keypad code lock.
// Depends on klc_pkg, klc_if, klc_lock_core, klc_motor_seq, klc_result_queue.
//
// Each request on item is a received key byte (op 0) or one timer tick
// (op 1). It lands in an input register; once the queue has room for two,
// the lock phase logic and the motor sequencer update their state in one
// pass and push one or two results into a four-entry result queue. A key
// is answered with 0 (key taken), with an acknowledge 1 followed by the new
// phase (or 6, denied, on a wrong code to open), or with send_valid low;
// alarm rides on the first result of a mismatch; motor_drive is the level
// after the item; last marks the final result of the item. Items with one
// result flow at one item per cycle while the result channel is ready;
// items with two are limited by the queue draining one result per cycle.
// The input side keeps taking items while results wait on a stalled result
// channel, until the queue lacks room for two more. The motor opens for
// MOVE_TICKS ticks, pauses PAUSE_TICKS ticks and closes for MOVE_TICKS
// ticks; the phase number is sent at the end of the pause and of closing.
module keypad_code_lock_controller_core import klc_pkg::*; #(
	parameter int CODE_LENGTH = 5,
	parameter int MOVE_TICKS  = 450,
	parameter int PAUSE_TICKS = 90
) (
	input  logic         clk,
	input  logic         arst_n,
	klc_item_if.sink     item,
	klc_result_if.source result
);

	// input register
	logic       v_s1;
	logic       op_s1;
	logic [7:0] key_s1;

	logic        room, fire;
	lock_phase_t phase;
	lock_res_t   lres;
	motor_res_t  mres;
	result_t     r0, r1;
	logic        push1;

	assign fire       = v_s1 && room;
	assign item.ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1  <= item.op;
			key_s1 <= item.key;
		end
	end

	klc_lock_core #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.key_en (fire && !op_s1),
		.key    (key_s1),
		.phase  (phase),
		.res    (lres)
	);

	klc_motor_seq #(
		.MOVE_TICKS  (MOVE_TICKS),
		.PAUSE_TICKS (PAUSE_TICKS)
	) u_motor (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (fire && op_s1),
		.start  (lres.motor_start),
		.res    (mres)
	);

	// assemble the results of this item; a key item with nothing to say and
	// an uneventful tick both give a single result with send_valid low
	always_comb begin
		r0.motor_drive = mres.drive;
		r1.motor_drive = mres.drive;
		r1.send_valid  = 1'b1;
		r1.send_byte   = lres.second_byte;
		r1.alarm       = 1'b0;
		r1.last        = 1'b1;
		if (op_s1) begin
			r0.send_valid = mres.send;
			r0.send_byte  = mres.send ? {5'd0, phase} : SEND_TAKEN;
			r0.alarm      = 1'b0;
			r0.last       = 1'b1;
			push1         = 1'b0;
		end else begin
			r0.send_valid = lres.send0;
			r0.send_byte  = lres.send0 ? lres.first_byte : SEND_TAKEN;
			r0.alarm      = lres.alarm;
			r0.last       = !lres.send1;
			push1         = lres.send1;
		end
	end

	klc_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (fire),
		.push1  (fire && push1),
		.d0     (r0),
		.d1     (r1),
		.room   (room),
		.result (result)
	);

endmodule
